// ===== rtl/rbst_pkg.sv =====
// Shared types for the ray versus box slab test.
package rbst_pkg;

  // Per-axis status for a zero direction component
  typedef struct packed {
    logic dzero;    // direction component is zero
    logic in_slab;  // min <= origin <= max
    logic below;    // origin < min
  } rbst_axis_flags_t;

endpackage

// ===== rtl/rbst_div_lane.sv =====
// Pipelined fixed-point divider lane: one quotient bit per stage, saturating result.
module rbst_div_lane #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic [W-1:0]        num,
  input  logic [W-1:0]        den,
  input  logic                neg,
  output logic signed [W-1:0] quo
);

  localparam int S = W + F;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0] r   [S];
  logic [W-1:0] u   [S];
  logic [W-1:0] q   [S];
  logic [W-1:0] d   [S];
  logic         sat [S];
  logic         ng  [S];

  for (genvar s = 0; s < S; s++) begin : g_stage
    logic [W-1:0] r_in, u_in, q_in, d_in;
    logic         sat_in, ng_in;
    logic [W:0]   sh, diff;
    logic         qb;

    if (s == 0) begin : g_first
      assign r_in   = '0;
      assign u_in   = num;
      assign q_in   = '0;
      assign d_in   = den;
      assign sat_in = 1'b0;
      assign ng_in  = neg;
    end else begin : g_next
      assign r_in   = r[s-1];
      assign u_in   = u[s-1];
      assign q_in   = q[s-1];
      assign d_in   = d[s-1];
      assign sat_in = sat[s-1];
      assign ng_in  = ng[s-1];
    end

    // remainder stays below the divisor, so the shifted value fits W+1 bits
    assign sh   = {r_in, u_in[W-1]};
    assign diff = sh - {1'b0, d_in};
    assign qb   = !diff[W];

    always_ff @(posedge clk) begin
      if (en) begin
        r[s]   <= qb ? diff[W-1:0] : sh[W-1:0];
        u[s]   <= {u_in[W-2:0], 1'b0};
        q[s]   <= {q_in[W-2:0], qb};
        sat[s] <= sat_in | q_in[W-1];
        d[s]   <= d_in;
        ng[s]  <= ng_in;
      end
    end
  end

  logic [W-1:0] qf;
  logic         over_pos, over_neg;

  assign qf       = q[S-1];
  assign over_pos = sat[S-1] | qf[W-1];
  assign over_neg = sat[S-1] | (qf[W-1] & (|qf[W-2:0]));

  always_ff @(posedge clk) begin
    if (en) begin
      if (ng[S-1]) begin
        quo <= over_neg ? WMIN : (~qf + 1'b1);
      end else begin
        quo <= over_pos ? WMAX : qf;
      end
    end
  end

endmodule

// ===== rtl/ray_box_slab_test.sv =====
// Top level: ray versus axis-aligned box slab test in signed fixed point.
// One ray/box item enters per cycle and one result (hit, distance) leaves per
// cycle while the output is not stalled. Values are Q16.16 by default. Items pass
// the stage A register, the six divider lanes (one quotient bit per pipeline stage),
// stage B and the output register. The whole pipeline advances together and holds while the output item is stalled.
module ray_box_slab_test #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [WORD_BITS-1:0] box_min_x,
  input  logic signed [WORD_BITS-1:0] box_min_y,
  input  logic signed [WORD_BITS-1:0] box_min_z,
  input  logic signed [WORD_BITS-1:0] box_max_x,
  input  logic signed [WORD_BITS-1:0] box_max_y,
  input  logic signed [WORD_BITS-1:0] box_max_z,
  input  logic signed [WORD_BITS-1:0] ray_origin_x,
  input  logic signed [WORD_BITS-1:0] ray_origin_y,
  input  logic signed [WORD_BITS-1:0] ray_origin_z,
  input  logic signed [WORD_BITS-1:0] ray_dir_x,
  input  logic signed [WORD_BITS-1:0] ray_dir_y,
  input  logic signed [WORD_BITS-1:0] ray_dir_z,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        hit,
  output logic signed [WORD_BITS-1:0] distance
);

  localparam int W = WORD_BITS;
  localparam int L = WORD_BITS + FRAC_BITS + 1;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic signed [W-1:0] lo [3];
  logic signed [W-1:0] hi [3];
  logic signed [W-1:0] org [3];
  logic signed [W-1:0] dir [3];

  assign lo[0] = box_min_x;  assign lo[1] = box_min_y;  assign lo[2] = box_min_z;
  assign hi[0] = box_max_x;  assign hi[1] = box_max_y;  assign hi[2] = box_max_z;
  assign org[0] = ray_origin_x; assign org[1] = ray_origin_y; assign org[2] = ray_origin_z;
  assign dir[0] = ray_dir_x;  assign dir[1] = ray_dir_y;  assign dir[2] = ray_dir_z;

  // stage A: differences, magnitudes, signs, zero-direction flags
  logic                      a_valid;
  logic [W-1:0]              a_num_lo [3];
  logic [W-1:0]              a_num_hi [3];
  logic [W-1:0]              a_den    [3];
  logic                      a_neg_lo [3];
  logic                      a_neg_hi [3];
  rbst_pkg::rbst_axis_flags_t a_flags [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis_in
    logic [W:0]   dlo, dhi, mlo, mhi;
    logic [W-1:0] mden;

    assign dlo  = {lo[a][W-1], lo[a]} - {org[a][W-1], org[a]};
    assign dhi  = {hi[a][W-1], hi[a]} - {org[a][W-1], org[a]};
    assign mlo  = dlo[W] ? (~dlo + 1'b1) : dlo;
    assign mhi  = dhi[W] ? (~dhi + 1'b1) : dhi;
    assign mden = dir[a][W-1] ? (~dir[a] + 1'b1) : dir[a];

    always_ff @(posedge clk) begin
      if (en) begin
        a_num_lo[a]      <= mlo[W-1:0];
        a_num_hi[a]      <= mhi[W-1:0];
        a_den[a]         <= mden;
        a_neg_lo[a]      <= dlo[W] ^ dir[a][W-1];
        a_neg_hi[a]      <= dhi[W] ^ dir[a][W-1];
        a_flags[a].dzero   <= (dir[a] == '0);
        a_flags[a].in_slab <= (lo[a] <= org[a]) && (org[a] <= hi[a]);
        a_flags[a].below   <= (org[a] < lo[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  // divider lanes
  logic signed [W-1:0] t1 [3];
  logic signed [W-1:0] t2 [3];

  for (genvar a = 0; a < 3; a++) begin : g_div
    rbst_div_lane #(.W(W), .F(FRAC_BITS)) u_div_lo (
      .clk(clk), .en(en), .num(a_num_lo[a]), .den(a_den[a]),
      .neg(a_neg_lo[a]), .quo(t1[a])
    );
    rbst_div_lane #(.W(W), .F(FRAC_BITS)) u_div_hi (
      .clk(clk), .en(en), .num(a_num_hi[a]), .den(a_den[a]),
      .neg(a_neg_hi[a]), .quo(t2[a])
    );
  end

  // sideband delay matching the divider latency
  logic                       v_pipe [L];
  rbst_pkg::rbst_axis_flags_t f_pipe [L][3];

  for (genvar s = 0; s < L; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        v_pipe[s] <= 1'b0;
      end else if (en) begin
        v_pipe[s] <= (s == 0) ? a_valid : v_pipe[(s == 0) ? 0 : s-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int a = 0; a < 3; a++) begin
          f_pipe[s][a] <= (s == 0) ? a_flags[a] : f_pipe[(s == 0) ? 0 : s-1][a];
        end
      end
    end
  end

  // stage B: per-axis entry/exit and reduction over the three axes
  logic                b_valid;
  logic                b_forced;
  logic signed [W-1:0] b_entry, b_exit;

  logic                c_forced;
  logic signed [W-1:0] c_entry, c_exit;

  always_comb begin
    logic signed [W-1:0] n, f;
    rbst_pkg::rbst_axis_flags_t fl;
    c_entry  = WMIN;
    c_exit   = WMAX;
    c_forced = 1'b0;
    for (int a = 0; a < 3; a++) begin
      fl = f_pipe[L-1][a];
      if (fl.dzero) begin
        n = fl.below ? WMAX : WMIN;
        f = n;
      end else begin
        n = (t1[a] < t2[a]) ? t1[a] : t2[a];
        f = (t1[a] < t2[a]) ? t2[a] : t1[a];
      end
      if (!(fl.dzero && fl.in_slab)) begin
        if (fl.dzero) c_forced = 1'b1;
        if (n > c_entry) c_entry = n;
        if (f < c_exit) c_exit = f;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= v_pipe[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_forced <= c_forced;
      b_entry  <= c_entry;
      b_exit   <= c_exit;
    end
  end

  // output register
  logic hit_next;
  assign hit_next = !b_forced && !b_exit[W-1] && (b_entry <= b_exit);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit      <= hit_next;
      distance <= hit_next ? b_entry : b_exit;
    end
  end

  a_forced_miss: assert property (@(posedge clk) disable iff (rst)
    (en && b_valid && b_forced) |=> (out_valid && !hit))
    else $error("forced axis did not give a miss");

  a_neg_exit_miss: assert property (@(posedge clk) disable iff (rst)
    (en && b_valid && b_exit[W-1]) |=> (out_valid && !hit))
    else $error("negative exit reported as hit");

  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    (en && b_valid && hit_next) |=> (out_valid && hit && (distance == $past(b_entry))))
    else $error("hit distance is not the entry");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule
